### src/rsc_pkg.sv
// ----------------------------------------------------------------------------
// rsc_pkg
// Shared types, constants and helpers for the RPN stack calculator.
// ----------------------------------------------------------------------------
package rsc_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int FRAC_BITS   = 16;
    localparam int DATA_W      = 48;
    localparam int FUNC_W      = 3;
    localparam int STATUS_W    = 3;

    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int PROD_W      = 2 * DATA_W;
    localparam int NUM_W       = DATA_W + FRAC_BITS;
    localparam int DCNT_W      = $clog2(NUM_W);
    localparam int MUL_CHUNK   = 16;
    localparam int MUL_STEPS   = DATA_W / MUL_CHUNK;
    localparam int MCNT_W      = $clog2(MUL_STEPS);
    localparam int PP_W        = DATA_W + MUL_CHUNK;

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    localparam logic [FUNC_W-1:0] FN_PUSH  = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_SUB   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_MUL   = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DIV   = 3'd4;
    localparam logic [FUNC_W-1:0] FN_PRINT = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 3'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_POP_R,
        S_LOAD_R,
        S_POP_L,
        S_LOAD_L,
        S_ARITH,
        S_MUL_RUN,
        S_MUL_FIN,
        S_DIV_RUN,
        S_DIV_FIN,
        S_PUSH_RES,
        S_DONE
    } rsc_state_t;

    typedef struct packed {
        logic accept;
        logic push_in;
        logic set_unknown;
        logic pop;
        logic load_r;
        logic load_l;
        logic arith;
        logic mul_step;
        logic mul_fin;
        logic div_step;
        logic div_fin;
        logic push_res;
        logic out_load;
    } rsc_cmd_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic              r_zero;
        logic              mul_last;
        logic              div_last;
    } rsc_stat_t;

    function automatic logic [DATA_W-1:0] mag(input logic [DATA_W-1:0] v);
        return v[DATA_W-1] ? (~v + 1'b1) : v;
    endfunction

    // signed saturation of an unsigned magnitude
    function automatic logic [DATA_W-1:0] sat_mag(input logic [PROD_W-1:0] m,
                                                  input logic neg);
        logic big;
        big = |m[PROD_W-1:DATA_W-1];
        if (neg) begin
            return big ? Q_MIN : (~m[DATA_W-1:0] + 1'b1);
        end
        return big ? Q_MAX : m[DATA_W-1:0];
    endfunction

endpackage

### src/rpn_stack_calculator_unit.sv
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit
// Reverse Polish calculator on a 64-entry stack of signed Q32.16 values.
// ----------------------------------------------------------------------------
//  channel | ports                          | direction
//  --------+--------------------------------+----------
//  input   | s_valid s_ready s_func         | in
//          | s_operand                      |
//  result  | m_valid m_ready m_printed      | out
//          | m_value m_status               |
//
//  One token at a time. Multiply sums three 48x16 partial products, and
//  divide uses a restoring divider, one quotient bit per cycle over 64 bits.
//  The stack RAM read is registered, so each pop takes a pop state and a
//  load state.
//  A new token is taken while the previous result beat is still waiting;
//  a stalled result holds the sequencer only at the final step.
//  Synchronous active-low reset empties the stack; no clearing pass.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rsc_pkg::FUNC_W-1:0]        s_func,
    input  logic signed [rsc_pkg::DATA_W-1:0] s_operand,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_printed,
    output logic signed [rsc_pkg::DATA_W-1:0] m_value,
    output logic [rsc_pkg::STATUS_W-1:0]      m_status
);

    rsc_pkg::rsc_cmd_t  cmd;
    rsc_pkg::rsc_stat_t stat;

    rsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rsc_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_func    (s_func),
        .s_operand (s_operand),
        .m_printed (m_printed),
        .m_value   (m_value),
        .m_status  (m_status)
    );

endmodule

### src/rsc_ram.sv
// ----------------------------------------------------------------------------
// rsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/rsc_datapath.sv
// ----------------------------------------------------------------------------
// rsc_datapath
// Operand stack, pop/push pointer, add/sub, chunked multiplier and
// restoring divider, and the result register.
// ----------------------------------------------------------------------------
module rsc_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  rsc_pkg::rsc_cmd_t              cmd,
    output rsc_pkg::rsc_stat_t             stat,
    input  logic [rsc_pkg::FUNC_W-1:0]     s_func,
    input  logic signed [rsc_pkg::DATA_W-1:0] s_operand,
    output logic                           m_printed,
    output logic signed [rsc_pkg::DATA_W-1:0] m_value,
    output logic [rsc_pkg::STATUS_W-1:0]   m_status
);

    logic [rsc_pkg::FUNC_W-1:0]   func_reg, func_next;
    logic [rsc_pkg::DATA_W-1:0]   opnd_reg, opnd_next;
    logic [rsc_pkg::DEPTH_W-1:0]  depth_reg, depth_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic                         under_reg, under_next;
    logic [rsc_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [rsc_pkg::DATA_W-1:0]   r_reg, r_next;
    logic [rsc_pkg::DATA_W-1:0]   l_reg, l_next;
    logic [rsc_pkg::DATA_W-1:0]   res_reg, res_next;
    logic [rsc_pkg::DATA_W-1:0]   ua_reg, ua_next;
    logic [rsc_pkg::DATA_W-1:0]   ub_reg, ub_next;
    logic                         neg_reg, neg_next;
    logic [rsc_pkg::PROD_W-1:0]   prod_reg, prod_next;
    logic [rsc_pkg::MCNT_W-1:0]   mcnt_reg, mcnt_next;
    logic [rsc_pkg::NUM_W-1:0]    nq_reg, nq_next;
    logic [rsc_pkg::DATA_W-1:0]   rem_reg, rem_next;
    logic [rsc_pkg::DCNT_W-1:0]   dcnt_reg, dcnt_next;
    logic                         prn_reg, prn_next;
    logic [rsc_pkg::DATA_W-1:0]   val_reg, val_next;
    logic [rsc_pkg::STATUS_W-1:0] ost_reg, ost_next;

    logic                         full;
    logic                         we;
    logic [rsc_pkg::DATA_W-1:0]   wdata;
    logic [rsc_pkg::DEPTH_W-1:0]  depth_m1;
    logic [rsc_pkg::DATA_W-1:0]   rdata;
    logic [rsc_pkg::DATA_W:0]     sum;
    logic [rsc_pkg::MUL_CHUNK-1:0] chunk;
    logic [rsc_pkg::PP_W-1:0]     pp;
    logic [rsc_pkg::DATA_W:0]     rem_sh;
    logic                         q_bit;

    assign full     = (depth_reg == rsc_pkg::DEPTH_W'(rsc_pkg::STACK_DEPTH));
    assign depth_m1 = depth_reg - 1'b1;
    assign we       = (cmd.push_in && !full) || cmd.push_res;
    assign wdata    = cmd.push_res ? res_reg : opnd_reg;

    rsc_ram #(
        .WIDTH (rsc_pkg::DATA_W),
        .DEPTH (rsc_pkg::STACK_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (we),
        .waddr (depth_reg[rsc_pkg::ADDR_W-1:0]),
        .wdata (wdata),
        .raddr (depth_m1[rsc_pkg::ADDR_W-1:0]),
        .rdata (rdata)
    );

    assign chunk  = ub_reg[mcnt_reg*rsc_pkg::MUL_CHUNK +: rsc_pkg::MUL_CHUNK];
    assign pp     = ua_reg * chunk;
    assign rem_sh = {rem_reg, nq_reg[rsc_pkg::NUM_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, ub_reg});

    assign stat.func     = func_reg;
    assign stat.r_zero   = (r_reg == '0);
    assign stat.mul_last = (mcnt_reg == rsc_pkg::MCNT_W'(rsc_pkg::MUL_STEPS - 1));
    assign stat.div_last = (dcnt_reg == rsc_pkg::DCNT_W'(rsc_pkg::NUM_W - 1));

    always_comb begin
        func_next    = func_reg;
        opnd_next    = opnd_reg;
        depth_next   = depth_reg;
        rd_pend_next = rd_pend_reg;
        under_next   = under_reg;
        st_next      = st_reg;
        r_next       = r_reg;
        l_next       = l_reg;
        res_next     = res_reg;
        ua_next      = ua_reg;
        ub_next      = ub_reg;
        neg_next     = neg_reg;
        prod_next    = prod_reg;
        mcnt_next    = mcnt_reg;
        nq_next      = nq_reg;
        rem_next     = rem_reg;
        dcnt_next    = dcnt_reg;
        prn_next     = prn_reg;
        val_next     = val_reg;
        ost_next     = ost_reg;
        sum          = '0;

        if (cmd.accept) begin
            func_next  = s_func;
            opnd_next  = s_operand;
            under_next = 1'b0;
            st_next    = rsc_pkg::ST_OK;
        end
        if (cmd.push_in) begin
            if (full) begin
                st_next = rsc_pkg::ST_OVERFLOW;
            end else begin
                depth_next = depth_reg + 1'b1;
            end
        end
        if (cmd.set_unknown) begin
            st_next = rsc_pkg::ST_UNKNOWN;
        end
        if (cmd.pop) begin
            if (depth_reg == '0) begin
                under_next   = 1'b1;
                rd_pend_next = 1'b0;
            end else begin
                depth_next   = depth_m1;
                rd_pend_next = 1'b1;
            end
        end
        if (cmd.load_r) begin
            r_next = rd_pend_reg ? rdata : '0;
        end
        if (cmd.load_l) begin
            l_next = rd_pend_reg ? rdata : '0;
        end
        if (cmd.arith) begin
            ua_next   = rsc_pkg::mag(l_reg);
            ub_next   = rsc_pkg::mag(r_reg);
            neg_next  = l_reg[rsc_pkg::DATA_W-1] ^ r_reg[rsc_pkg::DATA_W-1];
            prod_next = '0;
            mcnt_next = '0;
            nq_next   = {rsc_pkg::mag(l_reg), {rsc_pkg::FRAC_BITS{1'b0}}};
            rem_next  = '0;
            dcnt_next = '0;
            case (func_reg)
                rsc_pkg::FN_ADD: begin
                    sum = {l_reg[rsc_pkg::DATA_W-1], l_reg}
                        + {r_reg[rsc_pkg::DATA_W-1], r_reg};
                end
                rsc_pkg::FN_SUB: begin
                    sum = {l_reg[rsc_pkg::DATA_W-1], l_reg}
                        - {r_reg[rsc_pkg::DATA_W-1], r_reg};
                end
                default: begin
                    sum = '0;
                end
            endcase
            if (sum[rsc_pkg::DATA_W] != sum[rsc_pkg::DATA_W-1]) begin
                res_next = sum[rsc_pkg::DATA_W] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
            end else begin
                res_next = sum[rsc_pkg::DATA_W-1:0];
            end
            if (func_reg == rsc_pkg::FN_DIV && r_reg == '0) begin
                res_next = l_reg[rsc_pkg::DATA_W-1] ? rsc_pkg::Q_MIN : rsc_pkg::Q_MAX;
                st_next  = rsc_pkg::ST_DIVZERO;
            end
        end
        if (cmd.mul_step) begin
            prod_next = prod_reg
                      + (rsc_pkg::PROD_W'(pp) << (mcnt_reg*rsc_pkg::MUL_CHUNK));
            mcnt_next = mcnt_reg + 1'b1;
        end
        if (cmd.mul_fin) begin
            res_next = rsc_pkg::sat_mag(prod_reg >> rsc_pkg::FRAC_BITS, neg_reg);
        end
        if (cmd.div_step) begin
            rem_next  = q_bit ? rsc_pkg::DATA_W'(rem_sh - {1'b0, ub_reg})
                              : rem_sh[rsc_pkg::DATA_W-1:0];
            nq_next   = {nq_reg[rsc_pkg::NUM_W-2:0], q_bit};
            dcnt_next = dcnt_reg + 1'b1;
        end
        if (cmd.div_fin) begin
            res_next = rsc_pkg::sat_mag(rsc_pkg::PROD_W'(nq_reg), neg_reg);
        end
        if (cmd.push_res) begin
            depth_next = depth_reg + 1'b1;
        end
        if (cmd.out_load) begin
            prn_next = (func_reg == rsc_pkg::FN_PRINT);
            val_next = (func_reg == rsc_pkg::FN_PRINT) ? r_reg : '0;
            ost_next = under_reg ? rsc_pkg::ST_UNDERFLOW : st_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            rd_pend_reg <= 1'b0;
        end else begin
            depth_reg   <= depth_next;
            rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg  <= func_next;
        opnd_reg  <= opnd_next;
        under_reg <= under_next;
        st_reg    <= st_next;
        r_reg     <= r_next;
        l_reg     <= l_next;
        res_reg   <= res_next;
        ua_reg    <= ua_next;
        ub_reg    <= ub_next;
        neg_reg   <= neg_next;
        prod_reg  <= prod_next;
        mcnt_reg  <= mcnt_next;
        nq_reg    <= nq_next;
        rem_reg   <= rem_next;
        dcnt_reg  <= dcnt_next;
        prn_reg   <= prn_next;
        val_reg   <= val_next;
        ost_reg   <= ost_next;
    end

    assign m_printed = prn_reg;
    assign m_value   = val_reg;
    assign m_status  = ost_reg;

`ifndef SYNTHESIS
    a_depth_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        depth_reg <= rsc_pkg::DEPTH_W'(rsc_pkg::STACK_DEPTH))
        else $error("stack depth beyond capacity");

    a_no_write_full: assert property (@(posedge aclk) disable iff (!aresetn)
        we |-> !full)
        else $error("stack write while full");

    a_pop_dec: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.pop && depth_reg != '0) |=> depth_reg == $past(depth_m1))
        else $error("pop did not decrement depth");
`endif

endmodule

### src/rsc_ctrl.sv
// ----------------------------------------------------------------------------
// rsc_ctrl
// Sequencer for one token: decode, pops, arithmetic, push and result beat.
// ----------------------------------------------------------------------------
module rsc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rsc_pkg::rsc_stat_t  stat,
    output rsc_pkg::rsc_cmd_t   cmd
);

    rsc_pkg::rsc_state_t state_reg, state_next;
    logic                mv_reg, mv_next;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rsc_pkg::S_IDLE: begin
                if (s_valid) begin
                    state_next = rsc_pkg::S_DECODE;
                end
            end
            rsc_pkg::S_DECODE: begin
                case (stat.func)
                    rsc_pkg::FN_ADD, rsc_pkg::FN_SUB, rsc_pkg::FN_MUL,
                    rsc_pkg::FN_DIV, rsc_pkg::FN_PRINT: begin
                        state_next = rsc_pkg::S_POP_R;
                    end
                    default: begin
                        state_next = rsc_pkg::S_DONE;
                    end
                endcase
            end
            rsc_pkg::S_POP_R: state_next = rsc_pkg::S_LOAD_R;
            rsc_pkg::S_LOAD_R: begin
                state_next = (stat.func == rsc_pkg::FN_PRINT) ? rsc_pkg::S_DONE
                                                              : rsc_pkg::S_POP_L;
            end
            rsc_pkg::S_POP_L: state_next = rsc_pkg::S_LOAD_L;
            rsc_pkg::S_LOAD_L: state_next = rsc_pkg::S_ARITH;
            rsc_pkg::S_ARITH: begin
                if (stat.func == rsc_pkg::FN_MUL) begin
                    state_next = rsc_pkg::S_MUL_RUN;
                end else if (stat.func == rsc_pkg::FN_DIV && !stat.r_zero) begin
                    state_next = rsc_pkg::S_DIV_RUN;
                end else begin
                    state_next = rsc_pkg::S_PUSH_RES;
                end
            end
            rsc_pkg::S_MUL_RUN: begin
                if (stat.mul_last) begin
                    state_next = rsc_pkg::S_MUL_FIN;
                end
            end
            rsc_pkg::S_MUL_FIN: state_next = rsc_pkg::S_PUSH_RES;
            rsc_pkg::S_DIV_RUN: begin
                if (stat.div_last) begin
                    state_next = rsc_pkg::S_DIV_FIN;
                end
            end
            rsc_pkg::S_DIV_FIN: state_next = rsc_pkg::S_PUSH_RES;
            rsc_pkg::S_PUSH_RES: state_next = rsc_pkg::S_DONE;
            rsc_pkg::S_DONE: begin
                if (!mv_reg || m_ready) begin
                    state_next = rsc_pkg::S_IDLE;
                end
            end
            default: state_next = rsc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            rsc_pkg::S_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            rsc_pkg::S_DECODE: begin
                cmd.push_in     = (stat.func == rsc_pkg::FN_PUSH);
                cmd.set_unknown = (stat.func > rsc_pkg::FN_PRINT);
            end
            rsc_pkg::S_POP_R:    cmd.pop      = 1'b1;
            rsc_pkg::S_LOAD_R:   cmd.load_r   = 1'b1;
            rsc_pkg::S_POP_L:    cmd.pop      = 1'b1;
            rsc_pkg::S_LOAD_L:   cmd.load_l   = 1'b1;
            rsc_pkg::S_ARITH:    cmd.arith    = 1'b1;
            rsc_pkg::S_MUL_RUN:  cmd.mul_step = 1'b1;
            rsc_pkg::S_MUL_FIN:  cmd.mul_fin  = 1'b1;
            rsc_pkg::S_DIV_RUN:  cmd.div_step = 1'b1;
            rsc_pkg::S_DIV_FIN:  cmd.div_fin  = 1'b1;
            rsc_pkg::S_PUSH_RES: cmd.push_res = 1'b1;
            rsc_pkg::S_DONE:     cmd.out_load = !mv_reg || m_ready;
            default: begin
                cmd = '0;
            end
        endcase
    end

    always_comb begin
        mv_next = mv_reg;
        if (m_ready) begin
            mv_next = 1'b0;
        end
        if (cmd.out_load) begin
            mv_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rsc_pkg::S_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

    assign m_valid = mv_reg;

endmodule

### tb/sv/rsc_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsc_tb_pkg
// Result scoreboard for the RPN stack calculator testbench.
// Keeps a private operand stack, works out the result beat of every accepted
// token, and checks result beats against those expectations in order.
// ----------------------------------------------------------------------------
package rsc_tb_pkg;
    import rsc_pkg::*;

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic                printed;
        logic [DATA_W-1:0]   value;
        logic [STATUS_W-1:0] status;
    } calc_beat_t;

    class calc_scoreboard;
        logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
        int unsigned       depth;
        bit                popped_empty;
        calc_beat_t        expected_q [$];
        int unsigned       n_errors;
        int unsigned       n_checked;
        int unsigned       n_prints;
        int unsigned       status_seen [8];

        function new();
            depth     = 0;
            n_errors  = 0;
            n_checked = 0;
            n_prints  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [DATA_W-1:0] pop_entry();
            if (depth == 0) begin
                popped_empty = 1'b1;
                return '0;
            end
            depth--;
            return stack_mem[depth];
        endfunction

        function bit push_entry(logic [DATA_W-1:0] v);
            if (depth >= STACK_DEPTH) return 1'b0;
            stack_mem[depth] = v;
            depth++;
            return 1'b1;
        endfunction

        function logic [DATA_W-1:0] abs_q(logic [DATA_W-1:0] v);
            return v[DATA_W-1] ? ({DATA_W{1'b0}} - v) : v;
        endfunction

        // give a sign to a magnitude and clamp it to the Q range
        function logic [DATA_W-1:0] clamp_mag(logic [127:0] m, bit neg);
            if (neg) begin
                return (m >= (128'd1 << (DATA_W - 1))) ? Q_MIN
                                                       : ({DATA_W{1'b0}} - m[DATA_W-1:0]);
            end
            return (m > 128'(Q_MAX)) ? Q_MAX : m[DATA_W-1:0];
        endfunction

        function logic [DATA_W-1:0] add_sat(logic [DATA_W-1:0] l, logic [DATA_W-1:0] r,
                                            bit minus);
            longint sum;
            sum = minus ? longint'($signed(l)) - longint'($signed(r))
                        : longint'($signed(l)) + longint'($signed(r));
            if (sum > longint'($signed(Q_MAX))) return Q_MAX;
            if (sum < longint'($signed(Q_MIN))) return Q_MIN;
            return sum[DATA_W-1:0];
        endfunction

        function logic [DATA_W-1:0] mul_q(logic [DATA_W-1:0] l, logic [DATA_W-1:0] r);
            logic [127:0] prod;
            prod = 128'(abs_q(l)) * 128'(abs_q(r));
            return clamp_mag(prod >> FRAC_BITS, l[DATA_W-1] ^ r[DATA_W-1]);
        endfunction

        function logic [DATA_W-1:0] div_q(logic [DATA_W-1:0] l, logic [DATA_W-1:0] r);
            logic [127:0] num;
            num = 128'(abs_q(l)) << FRAC_BITS;
            return clamp_mag(num / 128'(abs_q(r)), l[DATA_W-1] ^ r[DATA_W-1]);
        endfunction

        function void note_token(logic [FUNC_W-1:0] fn, logic [DATA_W-1:0] operand);
            calc_beat_t        beat;
            logic [DATA_W-1:0] lhs;
            logic [DATA_W-1:0] rhs;
            logic [DATA_W-1:0] res;
            bit                by_zero;
            beat         = '0;
            popped_empty = 1'b0;
            by_zero      = 1'b0;
            case (fn)
                FN_PUSH: begin
                    if (!push_entry(operand)) beat.status = ST_OVERFLOW;
                end
                FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                    rhs = pop_entry();
                    lhs = pop_entry();
                    case (fn)
                        FN_ADD: res = add_sat(lhs, rhs, 1'b0);
                        FN_SUB: res = add_sat(lhs, rhs, 1'b1);
                        FN_MUL: res = mul_q(lhs, rhs);
                        default: begin
                            if (rhs == '0) begin
                                by_zero = 1'b1;
                                res     = lhs[DATA_W-1] ? Q_MIN : Q_MAX;
                            end else begin
                                res = div_q(lhs, rhs);
                            end
                        end
                    endcase
                    void'(push_entry(res));
                    beat.status = popped_empty ? ST_UNDERFLOW : (by_zero ? ST_DIVZERO : ST_OK);
                end
                FN_PRINT: begin
                    beat.value   = pop_entry();
                    beat.printed = 1'b1;
                    beat.status  = popped_empty ? ST_UNDERFLOW : ST_OK;
                end
                default: begin
                    beat.status = ST_UNKNOWN;
                end
            endcase
            expected_q.push_back(beat);
            status_seen[beat.status]++;
            n_prints += beat.printed;
        endfunction

        task report_mismatch(string msg);
            n_errors++;
            if (n_errors <= MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
        endtask

        task check_beat(logic printed, logic [DATA_W-1:0] value, logic [STATUS_W-1:0] status);
            calc_beat_t want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with nothing expected", n_checked));
                n_checked++;
                return;
            end
            want = expected_q.pop_front();
            if (printed !== want.printed)
                report_mismatch($sformatf("beat %0d printed: got %b want %b",
                                          n_checked, printed, want.printed));
            if (value !== want.value)
                report_mismatch($sformatf("beat %0d value: got %h want %h",
                                          n_checked, value, want.value));
            if (status !== want.status)
                report_mismatch($sformatf("beat %0d status: got %0d want %0d",
                                          n_checked, status, want.status));
            n_checked++;
        endtask

        task close_out();
            if (expected_q.size() != 0)
                report_mismatch($sformatf("%0d expected result beats never arrived",
                                          expected_q.size()));
        endtask
    endclass

endpackage

### tb/sv/rpn_stack_calculator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpn_stack_calculator_unit_tb
// Self-checking testbench for the RPN stack calculator.
// Sends directed tokens for edge cases, then random RPN expressions with
// stack fills and malformed tokens, while both channels stall at random.
// Every result beat is checked against the scoreboard's prediction.
// ----------------------------------------------------------------------------
module rpn_stack_calculator_unit_tb;
    import rsc_pkg::*;
    import rsc_tb_pkg::*;

    localparam int CLK_PERIOD     = 20;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_TOKENS  = 1750;
    localparam int QUIET_TAIL     = 250;
    localparam int HOLD_AT        = 500;
    localparam int LONG_HOLD      = 400;
    localparam int DRAIN_AT       = 1000;
    localparam int DRAIN_CYCLES   = 150;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [FUNC_W-1:0] FN_BAD_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_BAD_HI = 3'd7;
    localparam logic [DATA_W-1:0] Q_ONE     = DATA_W'(1) << FRAC_BITS;

    logic                     aclk;
    logic                     aresetn;
    logic                     s_valid;
    logic                     s_ready;
    logic [FUNC_W-1:0]        s_func;
    logic signed [DATA_W-1:0] s_operand;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_printed;
    logic signed [DATA_W-1:0] m_value;
    logic [STATUS_W-1:0]      m_status;

    calc_scoreboard sb;
    bit             quiet_tail   = 1'b0;
    bit             hold_req     = 1'b0;
    bit             hold_done    = 1'b0;
    bit             drained      = 1'b0;
    int             gen_depth    = 0;
    int             n_sent       = 0;
    int             n_directed   = 0;
    int unsigned    quiet_cycles = 0;

    rpn_stack_calculator_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_func    (s_func),
        .s_operand (s_operand),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_printed (m_printed),
        .m_value   (m_value),
        .m_status  (m_status)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // beat monitor and watchdog
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_token(s_func, s_operand);
            if (m_valid && m_ready) sb.check_beat(m_printed, m_value, m_status);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
                    $display("Some tests failed");
                    $finish;
                end
            end
        end
    end

    // result side: random ready runs and stalls, one long hold-off
    initial begin
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
            repeat ($urandom_range(1, 30)) begin
                @(negedge aclk);
                m_ready <= 1'b1;
            end
            if (!quiet_tail) begin
                repeat ($urandom_range(1, 6)) begin
                    @(negedge aclk);
                    m_ready <= 1'b0;
                end
            end
        end
    end

    function automatic void advance_depth(input logic [FUNC_W-1:0] fn);
        case (fn)
            FN_PUSH: begin
                if (gen_depth < STACK_DEPTH) gen_depth++;
            end
            FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
                gen_depth = (gen_depth >= 2) ? gen_depth - 1 : 1;
            end
            FN_PRINT: begin
                if (gen_depth > 0) gen_depth--;
            end
            default: ;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_operand();
        logic [63:0] raw;
        int          whole;
        raw   = {$urandom, $urandom};
        whole = int'($urandom_range(0, 400)) - 200;
        case ($urandom_range(0, 9))
            0, 1, 2: return raw[DATA_W-1:0];
            3, 4, 5: return (DATA_W'(whole) << FRAC_BITS) | DATA_W'(raw[FRAC_BITS-1:0]);
            6, 7:    return DATA_W'($signed(raw[31:0]));
            default: begin
                case ($urandom_range(0, 6))
                    0:       return Q_MAX;
                    1:       return Q_MIN;
                    2:       return '0;
                    3:       return DATA_W'(1);
                    4:       return '1;
                    5:       return Q_ONE;
                    default: return {DATA_W{1'b0}} - Q_ONE;
                endcase
            end
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_token();
        int roll;
        int push_pct;
        push_pct = (gen_depth < 2) ? 85 : ((gen_depth <= 16) ? 40 : 20);
        roll     = $urandom_range(0, 99);
        if (roll < push_pct) return FN_PUSH;
        roll = $urandom_range(0, 99);
        if (roll < 4)  return $urandom_range(0, 1) ? FN_BAD_LO : FN_BAD_HI;
        if (roll < 20) return FN_ADD;
        if (roll < 36) return FN_SUB;
        if (roll < 56) return FN_MUL;
        if (roll < 76) return FN_DIV;
        return FN_PRINT;
    endfunction

    task automatic send_token(input logic [FUNC_W-1:0] fn, input logic [DATA_W-1:0] operand);
        @(negedge aclk);
        s_valid   <= 1'b1;
        s_func    <= fn;
        s_operand <= operand;
        do @(posedge aclk); while (!s_ready);
        advance_depth(fn);
        n_sent++;
    endtask

    task automatic idle_input(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic wait_all_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // push until full, then a few pushes that must be dropped
    task automatic fill_stack();
        while (gen_depth < STACK_DEPTH) send_token(FN_PUSH, rand_operand());
        repeat ($urandom_range(1, 3)) send_token(FN_PUSH, rand_operand());
    endtask

    task automatic run_directed();
        send_token(FN_PRINT, '0);                   // print on empty stack
        send_token(FN_ADD, '0);                     // binary op on empty stack
        send_token(FN_DIV, '0);                     // one entry: underflow wins over div-by-zero
        send_token(FN_PRINT, '0);
        send_token(FN_PUSH, Q_MAX);
        send_token(FN_PUSH, Q_MAX);
        send_token(FN_ADD, '0);                     // positive saturation
        send_token(FN_PUSH, Q_MIN);
        send_token(FN_SUB, '0);
        send_token(FN_PUSH, Q_MIN);
        send_token(FN_MUL, '0);                     // negative saturation
        send_token(FN_PUSH, '1);                    // smallest negative step
        send_token(FN_MUL, '0);
        send_token(FN_PUSH, DATA_W'(-229376));      // -3.5
        send_token(FN_MUL, '0);
        send_token(FN_PUSH, '0);
        send_token(FN_DIV, '0);                     // negative over zero
        send_token(FN_PUSH, '0);
        send_token(FN_PUSH, '0);
        send_token(FN_DIV, '0);                     // zero over zero
        send_token(FN_DIV, '0);
        send_token(FN_PUSH, DATA_W'(-131072));      // -2.0
        send_token(FN_DIV, '0);
        send_token(FN_BAD_LO, Q_MAX);
        send_token(FN_BAD_HI, Q_MIN);
        send_token(FN_PRINT, '0);
    endtask

    task automatic run_random();
        int                n;
        logic [FUNC_W-1:0] fn;
        fill_stack();
        while (n_sent - n_directed < RANDOM_TOKENS) begin
            n          = n_sent - n_directed;
            quiet_tail = (n >= RANDOM_TOKENS - QUIET_TAIL);
            if (n >= HOLD_AT) hold_req = 1'b1;
            if (n >= DRAIN_AT && !drained) begin
                drained = 1'b1;
                wait_all_results();
            end
            if (!quiet_tail && (n % 100) < 70 && $urandom_range(0, 3) == 0)
                idle_input($urandom_range(1, 6));
            if ($urandom_range(0, 299) == 0) begin
                fill_stack();
            end else begin
                fn = pick_token();
                send_token(fn, (fn == FN_PUSH) ? rand_operand()
                                               : DATA_W'({$urandom, $urandom}));
            end
        end
    endtask

    initial begin
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_func    = FN_PUSH;
        s_operand = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        run_directed();
        n_directed = n_sent;
        run_random();

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        sb.close_out();

        $display("Covered %0d tokens (%0d directed), %0d result beats checked, %0d prints.",
                 n_sent, n_directed, sb.n_checked, sb.n_prints);
        $display("Status mix: ok %0d, underflow %0d, overflow %0d, div-by-zero %0d, unknown %0d.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_UNDERFLOW],
                 sb.status_seen[ST_OVERFLOW], sb.status_seen[ST_DIVZERO],
                 sb.status_seen[ST_UNKNOWN]);
        if (sb.n_errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
